@@ hdl/tilemap_text_console_unit_macros.svh @@
// Assertion macros for the tile map text console.
// Used by the top level; relies on i_clk and i_rst_n being in scope.
`ifndef TILEMAP_TEXT_CONSOLE_UNIT_MACROS_SVH
`define TILEMAP_TEXT_CONSOLE_UNIT_MACROS_SVH

// Check on every clock edge once reset is released.
`define TMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define TMC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hdl/tmc_pkg.sv @@
// Shared types and constants for the tile map text console.
// No dependencies; used by tmc_ctrl, tmc_dpath and the top level.
package tmc_pkg;

    // Map geometry limits
    localparam int MAX_WIDTH_LOG2  = 6;
    localparam int MAX_HEIGHT_LOG2 = 6;
    localparam int COL_W  = MAX_WIDTH_LOG2;
    localparam int ROW_W  = MAX_HEIGHT_LOG2;
    localparam int ADDR_W = MAX_WIDTH_LOG2 + MAX_HEIGHT_LOG2;
    localparam int TILE_W = 18;

    // Console operations
    localparam logic [2:0] ACT_CHAR  = 3'd0;
    localparam logic [2:0] ACT_MOVE  = 3'd1;
    localparam logic [2:0] ACT_CLS   = 3'd2;
    localparam logic [2:0] ACT_CLL   = 3'd3;
    localparam logic [2:0] ACT_PAL   = 3'd4;
    localparam logic [2:0] ACT_XCHG  = 3'd5;
    localparam logic [2:0] ACT_READ  = 3'd6;

    // Character codes
    localparam logic [7:0] CODE_NEWLINE = 8'h0A;
    localparam logic [7:0] CODE_FIRST   = 8'h20;
    localparam logic [7:0] CODE_COUNT   = 8'h60;
    localparam logic [15:0] SCROLL_STEP = 16'd8;
    localparam logic [7:0] PAL_LIMIT    = 8'd4;

    // Register indexes
    localparam logic [2:0] REG_WIDTH_LOG2    = 3'd0;
    localparam logic [2:0] REG_HEIGHT_LOG2   = 3'd1;
    localparam logic [2:0] REG_SCROLL_ENABLE = 3'd2;
    localparam logic [2:0] REG_VISIBLE_ROWS  = 3'd3;
    localparam logic [2:0] REG_FONT_COL_BASE = 3'd4;
    localparam logic [2:0] REG_FONT_ROW_BASE = 3'd5;
    localparam logic [2:0] REG_BLANK_TILE    = 3'd6;
    localparam logic [2:0] REG_V_SCROLL      = 3'd7;

    typedef struct packed {
        logic [2:0]        width_log2;
        logic [2:0]        height_log2;
        logic              scroll_enable;
        logic [5:0]        visible_rows;
        logic [7:0]        font_col_base;
        logic [7:0]        font_row_base;
        logic [TILE_W-1:0] blank_tile;
        logic [15:0]       v_scroll_start;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic cap;   // capture input transfer and cursor snapshot
        logic exec;  // perform the operation
        logic clr;   // write one blank tile of the sweep
        logic load;  // load the result register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic sweep;     // operation needs a clear sweep
        logic rd;        // operation reads the tile store
        logic last;      // sweep at its final entry
        logic out_free;  // result register can take a value
    } t_sts;

endpackage

@@ hdl/tilemap_text_console_unit.sv @@
// Tile map text console with an APB register port. One operation is taken at
// a time. An operation is captured, then executed; a tile read is loaded into
// the result only after the registered read port of the tile memory. A
// newline or a line clear writes 2^width_log2 blank tiles and a screen clear
// 2^(width_log2 + height_log2), with each log2 value capped at 6; the blank
// sweep writes one tile per cycle through the memory's single write port. An
// operation finishes only once the output register is free. A new operation
// is accepted while a finished result waits in the output register. The tile
// memory holds no defined contents after reset.
module tilemap_text_console_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // Operation channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [2:0]            i_action,
    input  logic [7:0]            i_char_code,
    input  logic signed [15:0]    i_new_x,
    input  logic signed [15:0]    i_new_y,
    input  logic [7:0]            i_new_pal,
    input  logic [11:0]           i_tile_index,
    // Result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [15:0]    o_prev_x,
    output logic signed [15:0]    o_prev_y,
    output logic [1:0]            o_prev_pal,
    output logic [15:0]           o_v_scroll,
    output logic                  o_bad_char,
    output logic [1:0]            o_read_pal,
    output logic [7:0]            o_read_col,
    output logic [7:0]            o_read_row
);

    `include "tilemap_text_console_unit_macros.svh"

    tmc_pkg::t_cfg r_cfg;
    tmc_pkg::t_cmd w_cmd;
    tmc_pkg::t_sts w_sts;
    logic          w_wr;
    logic [2:0]    w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_log2     <= 3'd5;
            r_cfg.height_log2    <= 3'd5;
            r_cfg.scroll_enable  <= 1'b0;
            r_cfg.visible_rows   <= 6'd29;
            r_cfg.font_col_base  <= '0;
            r_cfg.font_row_base  <= '0;
            r_cfg.blank_tile     <= '0;
            r_cfg.v_scroll_start <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                tmc_pkg::REG_WIDTH_LOG2:    r_cfg.width_log2     <= pwdata[2:0];
                tmc_pkg::REG_HEIGHT_LOG2:   r_cfg.height_log2    <= pwdata[2:0];
                tmc_pkg::REG_SCROLL_ENABLE: r_cfg.scroll_enable  <= pwdata[0];
                tmc_pkg::REG_VISIBLE_ROWS:  r_cfg.visible_rows   <= pwdata[5:0];
                tmc_pkg::REG_FONT_COL_BASE: r_cfg.font_col_base  <= pwdata[7:0];
                tmc_pkg::REG_FONT_ROW_BASE: r_cfg.font_row_base  <= pwdata[7:0];
                tmc_pkg::REG_BLANK_TILE:    r_cfg.blank_tile     <= pwdata[17:0];
                tmc_pkg::REG_V_SCROLL:      r_cfg.v_scroll_start <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (w_idx)
            tmc_pkg::REG_WIDTH_LOG2:    prdata = 32'(r_cfg.width_log2);
            tmc_pkg::REG_HEIGHT_LOG2:   prdata = 32'(r_cfg.height_log2);
            tmc_pkg::REG_SCROLL_ENABLE: prdata = 32'(r_cfg.scroll_enable);
            tmc_pkg::REG_VISIBLE_ROWS:  prdata = 32'(r_cfg.visible_rows);
            tmc_pkg::REG_FONT_COL_BASE: prdata = 32'(r_cfg.font_col_base);
            tmc_pkg::REG_FONT_ROW_BASE: prdata = 32'(r_cfg.font_row_base);
            tmc_pkg::REG_BLANK_TILE:    prdata = 32'(r_cfg.blank_tile);
            tmc_pkg::REG_V_SCROLL:      prdata = 32'(r_cfg.v_scroll_start);
            default:                    prdata = '0;
        endcase
    end

    tmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    tmc_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_action     (i_action),
        .i_char_code  (i_char_code),
        .i_new_x      (i_new_x),
        .i_new_y      (i_new_y),
        .i_new_pal    (i_new_pal),
        .i_tile_index (i_tile_index),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_prev_x     (o_prev_x),
        .o_prev_y     (o_prev_y),
        .o_prev_pal   (o_prev_pal),
        .o_v_scroll   (o_v_scroll),
        .o_bad_char   (o_bad_char),
        .o_read_pal   (o_read_pal),
        .o_read_col   (o_read_col),
        .o_read_row   (o_read_row)
    );

    // One operation in flight: an accepted transfer closes the input side
    `TMC_ASSERT(a_one_in_flight, (i_in_valid && !o_in_stall) |=> o_in_stall, "second transfer accepted while busy")
    // Result register is only loaded when it is empty or draining
    `TMC_ASSERT(a_load_free, w_cmd.load |-> (!o_out_valid || !i_out_stall), "result overwritten while stalled")
    // Blank sweep never overlaps acceptance of a new operation
    `TMC_ASSERT(a_sweep_busy, w_cmd.clr |-> (o_in_stall && !w_cmd.cap), "sweep while idle")

endmodule

@@ hdl/tmc_ctrl.sv @@
// Sequencing controller for the tile map text console.
// Depends on tmc_pkg for the command and status structs.
module tmc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  tmc_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output tmc_pkg::t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_CLEAR = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_stall = (r_state != ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.sweep) begin
                    n_state = ST_CLEAR;
                end else if (i_sts.rd) begin
                    n_state = ST_DONE;
                end else if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hdl/tmc_dpath.sv @@
// Datapath of the tile map text console: cursor, palette, scroll, tile memory,
// clear sweep counter and result register. Depends on tmc_pkg.
module tmc_dpath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tmc_pkg::t_cfg         i_cfg,
    input  tmc_pkg::t_cmd         i_cmd,
    output tmc_pkg::t_sts         o_sts,
    input  logic [2:0]            i_action,
    input  logic [7:0]            i_char_code,
    input  logic signed [15:0]    i_new_x,
    input  logic signed [15:0]    i_new_y,
    input  logic [7:0]            i_new_pal,
    input  logic [11:0]           i_tile_index,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic signed [15:0]    o_prev_x,
    output logic signed [15:0]    o_prev_y,
    output logic [1:0]            o_prev_pal,
    output logic [15:0]           o_v_scroll,
    output logic                  o_bad_char,
    output logic [1:0]            o_read_pal,
    output logic [7:0]            o_read_col,
    output logic [7:0]            o_read_row
);

    localparam int AW = tmc_pkg::ADDR_W;
    localparam int CW = tmc_pkg::COL_W;
    localparam int RW = tmc_pkg::ROW_W;
    localparam int TW = tmc_pkg::TILE_W;

    // Captured operation
    logic [2:0]  r_act;
    logic [7:0]  r_code;
    logic [15:0] r_nx;
    logic [15:0] r_ny;
    logic [7:0]  r_npal;
    logic [11:0] r_tidx;

    // Console state
    logic [15:0] r_cx, n_cx;
    logic [15:0] r_cy, n_cy;
    logic [1:0]  r_pal, n_pal;
    logic [15:0] r_scroll, n_scroll;
    logic [15:0] r_prev_x;
    logic [15:0] r_prev_y;
    logic [1:0]  r_prev_pal;

    // Sweep
    logic [AW-1:0] r_base, n_base;
    logic [AW-1:0] r_last, n_last;
    logic [AW-1:0] r_cnt;

    // Tile memory
    logic [TW-1:0] r_mem [0:(1<<AW)-1];
    logic [TW-1:0] r_rd_data;

    // Result register
    logic          r_out_valid;
    logic [15:0]   r_out_x;
    logic [15:0]   r_out_y;
    logic [1:0]    r_out_pal;
    logic [15:0]   r_out_scroll;
    logic          r_out_bad;
    logic [TW-1:0] r_out_tile;

    // Geometry
    logic [2:0]    w_wl;
    logic [2:0]    w_hl;
    logic [CW-1:0] w_wmask;
    logic [RW-1:0] w_hmask;
    logic [16:0]   w_width;
    logic [AW-1:0] w_scr_last;

    // Operation decode
    logic          w_nl;
    logic          w_bad;
    logic          w_sweep;
    logic          w_is_read;
    logic [7:0]    w_a;
    logic [15:0]   w_ny;
    logic [RW-1:0] w_row;
    logic [AW-1:0] w_char_addr;
    logic [TW-1:0] w_char_tile;
    logic          w_char_we;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [TW-1:0] w_wdata;

    // Saturated geometry and masks
    assign w_wl = (i_cfg.width_log2 > 3'(tmc_pkg::MAX_WIDTH_LOG2))
                ? 3'(tmc_pkg::MAX_WIDTH_LOG2) : i_cfg.width_log2;
    assign w_hl = (i_cfg.height_log2 > 3'(tmc_pkg::MAX_HEIGHT_LOG2))
                ? 3'(tmc_pkg::MAX_HEIGHT_LOG2) : i_cfg.height_log2;
    assign w_wmask    = CW'(((CW+1)'(1) << w_wl) - (CW+1)'(1));
    assign w_hmask    = RW'(((RW+1)'(1) << w_hl) - (RW+1)'(1));
    assign w_width    = 17'(1) << w_wl;
    assign w_scr_last = AW'(((AW+1)'(1) << ({1'b0, w_wl} + {1'b0, w_hl})) - (AW+1)'(1));

    // Character decode; newline only counts for a print operation
    assign w_a       = r_code - tmc_pkg::CODE_FIRST;
    assign w_nl      = (r_act == tmc_pkg::ACT_CHAR) && (r_code == tmc_pkg::CODE_NEWLINE);
    assign w_bad     = (r_act == tmc_pkg::ACT_CHAR) && !w_nl && (w_a >= tmc_pkg::CODE_COUNT);
    assign w_is_read = (r_act == tmc_pkg::ACT_READ);
    assign w_sweep   = ((r_act == tmc_pkg::ACT_CHAR) && w_nl)
                     || (r_act == tmc_pkg::ACT_CLS) || (r_act == tmc_pkg::ACT_CLL);
    assign w_ny      = r_cy + 16'd1;
    assign w_row     = (w_nl ? w_ny[RW-1:0] : r_cy[RW-1:0]) & w_hmask;

    assign w_char_addr = (AW'(r_cy[RW-1:0] & w_hmask) << w_wl) | AW'(r_cx[CW-1:0] & w_wmask);
    assign w_char_tile = {r_pal,
                          i_cfg.font_col_base + {4'd0, w_a[3:0]},
                          i_cfg.font_row_base + {5'd0, w_a[6:4]}};
    assign w_char_we   = i_cmd.exec && (r_act == tmc_pkg::ACT_CHAR) && !w_nl && !w_bad
                       && ($signed({r_cx[15], r_cx}) < $signed(w_width));

    // Single write port: character store or blank sweep
    assign w_we    = w_char_we || i_cmd.clr;
    assign w_waddr = i_cmd.clr ? (r_base | r_cnt) : w_char_addr;
    assign w_wdata = i_cmd.clr ? i_cfg.blank_tile : w_char_tile;

    // Operation effects
    always_comb begin
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_pal    = r_pal;
        n_scroll = r_scroll;
        n_base   = AW'(w_row) << w_wl;
        n_last   = AW'(w_wmask);
        case (r_act)
            tmc_pkg::ACT_CHAR: begin
                if (w_nl) begin
                    n_cx = 16'd0;
                    n_cy = w_ny;
                    if (i_cfg.scroll_enable
                        && ($signed(w_ny) > $signed({10'd0, i_cfg.visible_rows}))) begin
                        n_scroll = r_scroll + tmc_pkg::SCROLL_STEP;
                    end
                end else if (!w_bad) begin
                    n_cx = r_cx + 16'd1;
                end
            end
            tmc_pkg::ACT_MOVE: begin
                n_cx = r_nx;
                n_cy = r_ny;
            end
            tmc_pkg::ACT_CLS: begin
                n_base = '0;
                n_last = w_scr_last;
            end
            tmc_pkg::ACT_PAL: begin
                if (r_npal < tmc_pkg::PAL_LIMIT) begin
                    n_pal = r_npal[1:0];
                end
            end
            tmc_pkg::ACT_XCHG: begin
                n_cx = r_nx;
                n_cy = r_ny;
                if (r_npal < tmc_pkg::PAL_LIMIT) begin
                    n_pal = r_npal[1:0];
                end
            end
            default: ;
        endcase
    end

    // Status to controller
    assign o_sts.sweep    = w_sweep;
    assign o_sts.rd       = w_is_read;
    assign o_sts.last     = (r_cnt == r_last);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    // Console state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_pal    <= '0;
            r_scroll <= '0;
        end else if (i_cmd.exec) begin
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_pal    <= n_pal;
            r_scroll <= n_scroll;
        end
    end

    // Operation capture and cursor snapshot
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_act      <= i_action;
            r_code     <= i_char_code;
            r_nx       <= i_new_x;
            r_ny       <= i_new_y;
            r_npal     <= i_new_pal;
            r_tidx     <= i_tile_index;
            r_prev_x   <= r_cx;
            r_prev_y   <= r_cy;
            r_prev_pal <= r_pal;
        end
    end

    // Sweep bounds and counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_base <= n_base;
            r_last <= n_last;
            r_cnt  <= '0;
        end else if (i_cmd.clr) begin
            r_cnt  <= r_cnt + AW'(1);
        end
    end

    // Tile memory write port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    // Tile memory read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_is_read) begin
            r_rd_data <= r_mem[r_tidx[AW-1:0]];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_x      <= r_prev_x;
            r_out_y      <= r_prev_y;
            r_out_pal    <= r_prev_pal;
            r_out_scroll <= i_cfg.v_scroll_start + r_scroll;
            r_out_bad    <= w_bad;
            r_out_tile   <= w_is_read ? r_rd_data : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_prev_x    = r_out_x;
    assign o_prev_y    = r_out_y;
    assign o_prev_pal  = r_out_pal;
    assign o_v_scroll  = r_out_scroll;
    assign o_bad_char  = r_out_bad;
    assign o_read_pal  = r_out_tile[17:16];
    assign o_read_col  = r_out_tile[15:8];
    assign o_read_row  = r_out_tile[7:0];

endmodule
